// File: hdl/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types, codes and checksum functions of the packet checksum block.
// ----------------------------------------------------------------------------
package pcg_pkg;

  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 4;
  localparam int unsigned WordW     = 32;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned VersionW  = 2;

  localparam logic [WordW-1:0] CrcPoly = 32'hEDB88320;

  // Checksum size in bytes for versions 1 and 2
  localparam logic [LenW-1:0] SumSize  = 4'd8;
  localparam logic [LenW-1:0] NoSize   = 4'd0;

  // Protocol versions
  localparam logic [VersionW-1:0] VerNone  = 2'd0;
  localparam logic [VersionW-1:0] VerCount = 2'd1;
  localparam logic [VersionW-1:0] VerCrc   = 2'd2;

  typedef enum logic [OpcodeW-1:0] {
    OP_DATA     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_VALIDATE = 2'd2
  } pcg_op_e;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [ByteW-1:0]   data_byte;
    logic [LenW-1:0]    checksum_len;
    logic [ValueW-1:0]  expected_checksum;
  } pcg_item_t;

  typedef struct packed {
    logic              has_result;
    logic              ok;
    logic [ValueW-1:0] checksum_value;
    logic [LenW-1:0]   checksum_size;
  } pcg_result_t;

  // Reverse the bit order of a 32-bit word
  function automatic logic [WordW-1:0] reverse_word(input logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    for (int i = 0; i < WordW; i++) begin
      r[i] = v[WordW-1-i];
    end
    return r;
  endfunction

  // One byte of reflected CRC-32
  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc ^ {{(WordW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/pcg_ifs.sv
// ----------------------------------------------------------------------------
// pcg request and result channels
// Valid/ready channels carrying one request or one result each.
// ----------------------------------------------------------------------------
interface pcg_in_if;
  logic                             valid;
  logic                             ready;
  logic [pcg_pkg::OpcodeW-1:0]      opcode;
  logic [pcg_pkg::ByteW-1:0]        data_byte;
  logic [pcg_pkg::LenW-1:0]         checksum_len;
  logic [pcg_pkg::ValueW-1:0]       expected_checksum;

  modport source (output valid, opcode, data_byte, checksum_len, expected_checksum,
                  input ready);
  modport sink   (input valid, opcode, data_byte, checksum_len, expected_checksum,
                  output ready);
endinterface

interface pcg_out_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [pcg_pkg::ValueW-1:0]       checksum_value;
  logic [pcg_pkg::LenW-1:0]         checksum_size;

  modport source (output valid, ok, checksum_value, checksum_size, input ready);
  modport sink   (input valid, ok, checksum_value, checksum_size, output ready);
endinterface

// File: hdl/packet_checksum_gen_check.sv
// ----------------------------------------------------------------------------
// packet_checksum_gen_check
// Packet checksum generator and checker: byte count or reflected CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per handshake: a packet byte (opcode data), a
//   write-close or a validate-close. Data bytes produce no result; each close
//   produces exactly one result on out_o (ok, checksum_value, checksum_size).
//   cfg_we_i/cfg_wdata_i set the protocol version (0 none, 1 reversed byte
//   count, 2 CRC-32); write it only while the block is idle. A write of a
//   valid version clears the running sums; code 3 is dropped.
//   Path: a close passes from the request register into the result register,
//   whose contents show on out_o.
//   Throughput: one request per cycle unless a close waits on a stalled out_o;
//   the CRC advances one byte per cycle, xor network from request reg to CRC.
//   Reset: version 0, sums and both sequence counts cleared, no result held.
//   Stall: while a result waits on out_o, the request register still drains
//   data bytes; a pending close holds and in_i.ready drops until out_o
//   takes the waiting result.
// ----------------------------------------------------------------------------
module packet_checksum_gen_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcg_pkg::VersionW-1:0] cfg_wdata_i,
  pcg_in_if.sink                       in_i,
  pcg_out_if.source                    out_o
);
  import pcg_pkg::*;

  // Request register
  logic        req_valid_q;
  pcg_item_t   req_q;
  logic        req_advance;

  // Result register
  logic              out_valid_q;
  logic              out_ok_q;
  logic [ValueW-1:0] out_value_q;
  logic [LenW-1:0]   out_size_q;

  pcg_result_t res;
  logic        commit;
  logic        load_out;

  pcg_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (req_q),
    .commit_i    (commit),
    .res_o       (res)
  );

  // A request without a result always advances; a close needs room downstream
  assign req_advance = !res.has_result || !out_valid_q || out_o.ready;
  assign commit      = req_valid_q && req_advance;
  assign load_out    = commit && res.has_result;
  assign in_i.ready  = !req_valid_q || req_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      req_valid_q <= in_i.valid;
    end
  end

  // Capture the request payload whenever the register is free to take one
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      req_q.opcode            <= in_i.opcode;
      req_q.data_byte         <= in_i.data_byte;
      req_q.checksum_len      <= in_i.checksum_len;
      req_q.expected_checksum <= in_i.expected_checksum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result until taken; load only when the register is free
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_ok_q    <= res.ok;
      out_value_q <= res.checksum_value;
      out_size_q  <= res.checksum_size;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.ok             = out_ok_q;
  assign out_o.checksum_value = out_value_q;
  assign out_o.checksum_size  = out_size_q;

  // A nonzero checksum value only comes from a write in a version with a sum
  a_value_needs_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_value_q != '0 |-> out_size_q == SumSize && out_ok_q)
    else $error("nonzero checksum without checksum size");

  // A refused write or failed validate never carries a value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ok_q |-> out_value_q == '0)
    else $error("failed close carries a value");

  // Size is always zero or the full checksum size
  a_size_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_size_q == SumSize || out_size_q == NoSize)
    else $error("illegal checksum size");

  // A close never overwrites a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !load_out)
    else $error("result overwritten while stalled");

endmodule

// File: hdl/pcg_engine.sv
// ----------------------------------------------------------------------------
// pcg_engine
// Checksum state, version register and the combinational step of one request.
// ----------------------------------------------------------------------------
module pcg_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pcg_pkg::VersionW-1:0] cfg_wdata_i,
  input  pcg_pkg::pcg_item_t        item_i,
  input  logic                      commit_i,
  output pcg_pkg::pcg_result_t      res_o
);
  import pcg_pkg::*;

  logic [VersionW-1:0] version_q;
  logic [WordW-1:0]    crc_q, crc_d;
  logic [WordW-1:0]    count_q, count_d;
  logic [WordW-1:0]    wseq_q, wseq_d;
  logic [WordW-1:0]    rseq_q, rseq_d;

  logic [LenW-1:0]     size;
  logic [WordW-1:0]    sum;

  always_comb begin
    size = (version_q == VerCount || version_q == VerCrc) ? SumSize : NoSize;
    if (version_q == VerCount) begin
      sum = reverse_word(count_q);
    end else if (version_q == VerCrc) begin
      sum = crc_q;
    end else begin
      sum = '0;
    end
  end

  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    wseq_d  = wseq_q;
    rseq_d  = rseq_q;
    res_o   = '0;
    res_o.checksum_size = size;
    unique case (item_i.opcode)
      OP_DATA: begin
        if (version_q == VerCount) begin
          count_d = count_q + 1'b1;
        end else if (version_q == VerCrc) begin
          crc_d = crc_byte(crc_q, item_i.data_byte);
        end
      end
      OP_WRITE: begin
        res_o.has_result = 1'b1;
        if (item_i.checksum_len >= size) begin
          res_o.ok = 1'b1;
          if (size != NoSize) begin
            res_o.checksum_value = {wseq_q, sum};
          end
          crc_d   = '0;
          count_d = '0;
          wseq_d  = wseq_q + 1'b1;
        end
      end
      OP_VALIDATE: begin
        res_o.has_result = 1'b1;
        if (item_i.checksum_len == size) begin
          res_o.ok = (size == NoSize) || ({rseq_q, sum} == item_i.expected_checksum);
        end
        crc_d   = '0;
        count_d = '0;
        rseq_d  = rseq_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VerNone;
      crc_q     <= '0;
      count_q   <= '0;
      wseq_q    <= '0;
      rseq_q    <= '0;
    end else if (cfg_we_i) begin
      // drop the unused version code
      if (cfg_wdata_i == VerNone || cfg_wdata_i == VerCount || cfg_wdata_i == VerCrc) begin
        version_q <= cfg_wdata_i;
        crc_q     <= '0;
        count_q   <= '0;
      end
    end else if (commit_i) begin
      crc_q   <= crc_d;
      count_q <= count_d;
      wseq_q  <= wseq_d;
      rseq_q  <= rseq_d;
    end
  end

  // A committed accepted write advances the write count by exactly one
  a_wseq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && !cfg_we_i && res_o.has_result && res_o.ok
      && item_i.opcode == OP_WRITE |=> wseq_q == $past(wseq_q) + 1'b1)
    else $error("write count did not advance");

  // A committed validate always advances the read count
  a_rseq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && !cfg_we_i && item_i.opcode == OP_VALIDATE
      |=> rseq_q == $past(rseq_q) + 1'b1)
    else $error("read count did not advance");

  // Any committed close that succeeds leaves both sums cleared
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && !cfg_we_i && res_o.has_result && res_o.ok
      |=> crc_q == '0 && count_q == '0)
    else $error("sums not cleared after close");

endmodule
